// ===== design/pida_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pida_pkg: shared types and constants
// Sizes, request and status codes, and the command broadcast to the cell row.
// ----------------------------------------------------------------------------
package pida_pkg;

  localparam int DEPTH     = 256;
  localparam int WORD_BITS = 64;

  // field widths fixed by the interface
  localparam int REQ_W     = 2;
  localparam int POS_W     = 9;
  localparam int CNT_W     = 9;
  localparam int STAT_W    = 2;
  localparam int WORD_W    = 64;

  // cell index width (at least two bits so the read tree has two levels)
  localparam int IDX_W     = (DEPTH > 4) ? $clog2(DEPTH) : 2;
  // compare width: holds any cell index and any count or position
  localparam int CMP_W     = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;

  // read tree: low index bits pick within a group, high bits pick the group
  localparam int HI_BITS   = IDX_W / 2;
  localparam int LO_BITS   = IDX_W - HI_BITS;
  localparam int GRP       = 2 ** LO_BITS;
  localparam int NGRP      = 2 ** HI_BITS;

  // capacity after reset, saturated to the depth
  localparam int CAP_RESET = (256 > DEPTH) ? DEPTH : 256;

  typedef enum logic [REQ_W-1:0] {
    REQ_SET = 2'd0,
    REQ_GET = 2'd1,
    REQ_INS = 2'd2,
    REQ_DEL = 2'd3
  } req_kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic                 en;
    req_kind_t            kind;
    logic [CMP_W-1:0]     slot;
    logic [CMP_W-1:0]     count;
    logic [WORD_BITS-1:0] word;
  } cell_cmd_t;

endpackage

// ===== design/pida_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pida_cell: one storage cell of the row
// Holds one word and a valid bit; loads, or takes a neighbor's word on a shift.
// ----------------------------------------------------------------------------
module pida_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pida_pkg::cell_cmd_t           cmd,
  input  logic [pida_pkg::CMP_W-1:0]    idx,
  input  logic [pida_pkg::WORD_BITS-1:0] left_word,
  input  logic                          left_vld,
  input  logic [pida_pkg::WORD_BITS-1:0] right_word,
  input  logic                          right_vld,
  output logic [pida_pkg::WORD_BITS-1:0] word,
  output logic                          vld
);

  logic [pida_pkg::WORD_BITS-1:0] word_r, word_nxt;
  logic                           vld_r, vld_nxt;

  always_comb begin
    word_nxt = word_r;
    vld_nxt  = vld_r;
    if (cmd.en) begin
      case (cmd.kind)
        pida_pkg::REQ_SET: begin
          if (idx == cmd.slot) begin
            word_nxt = cmd.word;
            vld_nxt  = 1'b1;
          end
        end
        pida_pkg::REQ_INS: begin
          if (idx == cmd.slot) begin
            word_nxt = cmd.word;
            vld_nxt  = 1'b1;
          end else if (idx > cmd.slot && idx <= cmd.count) begin
            // shift up: take the word from the left
            word_nxt = left_word;
            vld_nxt  = left_vld;
          end
        end
        pida_pkg::REQ_DEL: begin
          if (idx >= cmd.slot && (idx + pida_pkg::CMP_W'(1)) < cmd.count) begin
            // shift down: take the word from the right
            word_nxt = right_word;
            vld_nxt  = right_vld;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    word_r <= word_nxt;
  end

  // never-written cells read as zero
  assign word = vld_r ? word_r : '0;
  assign vld  = vld_r;

endmodule

// ===== design/pida_rdmux.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pida_rdmux: two-level registered read selection over the cell row
// First level picks one word per group, second level picks the group.
// ----------------------------------------------------------------------------
module pida_rdmux (
  input  logic                           clk,
  input  logic [pida_pkg::WORD_BITS-1:0] words [pida_pkg::DEPTH],
  input  logic                           ld_grp,
  input  logic [pida_pkg::IDX_W-1:0]     slot,
  input  logic                           ld_out,
  output logic [pida_pkg::WORD_BITS-1:0] rd_word
);

  logic [pida_pkg::WORD_BITS-1:0] cand  [pida_pkg::NGRP][pida_pkg::GRP];
  logic [pida_pkg::WORD_BITS-1:0] grp_r [pida_pkg::NGRP];
  logic [pida_pkg::HI_BITS-1:0]   hi_r;
  logic [pida_pkg::WORD_BITS-1:0] rd_r;

  for (genvar g = 0; g < pida_pkg::NGRP; g++) begin : g_grp
    for (genvar k = 0; k < pida_pkg::GRP; k++) begin : g_k
      if (g * pida_pkg::GRP + k < pida_pkg::DEPTH) begin : g_live
        assign cand[g][k] = words[g * pida_pkg::GRP + k];
      end else begin : g_pad
        assign cand[g][k] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_grp) begin
      for (int g = 0; g < pida_pkg::NGRP; g++) begin
        grp_r[g] <= cand[g][slot[pida_pkg::LO_BITS-1:0]];
      end
      hi_r <= slot[pida_pkg::IDX_W-1:pida_pkg::LO_BITS];
    end
    if (ld_out) begin
      rd_r <= grp_r[hi_r];
    end
  end

  assign rd_word = rd_r;

endmodule

// ===== design/positional_insert_delete_array_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_insert_delete_array_unit: positional insert/delete word array
// Bounded array of words with a live count; set, get, insert before and delete
// at a 1-based position, shifting following words through a row of cells.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Ports              Contents
//  -------  ---  -----------------  ---------------------------------------
//  in       in   in_t{valid,ready}  tuser: req_type; tdata: position, word_in
//  out      out  out_t{valid,ready} tdata: word_out, status, count, is_empty
//  cfg      in   cfg_wr_{en,data}   array_capacity (also loads the count)
//
//  Each item passes the idle state, which latches the request on accept and
//  loads the first level of the read tree, then the read state, which selects
//  the word, then the write-back state, which commits the update to the cell
//  row and loads the result. The two-level read tree sets this sequence; every
//  cell shifts in the same commit, so insert and delete add no extra state.
//  A held result stalls the commit of the following transaction; that one is
//  still taken, but the input then waits until the held result drains.
//  Synchronous active-low reset clears all cells and sets capacity and count
//  to 256 (saturated to the depth).
//
module positional_insert_delete_array_unit (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [8:0]  cfg_wr_data,   // array_capacity
  // request stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,      // [1:0] req_type
  input  logic [79:0] in_tdata,      // [8:0] position, [72:9] word_in, [79:73] zero
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata      // [63:0] word_out, [65:64] status,
                                     // [74:66] element_count, [75] is_empty, [79:76] zero
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_WB
  } state_t;

  state_t state_r;

  // latched request
  pida_pkg::req_kind_t               kind_r;
  logic [pida_pkg::POS_W-1:0]        pos_r;
  logic [pida_pkg::WORD_BITS-1:0]    word_r;

  // capacity and live count
  logic [pida_pkg::CNT_W-1:0]        cap_r, cap_nxt;
  logic [pida_pkg::CNT_W-1:0]        count_r, count_nxt;

  // result register
  logic                              out_vld_r;
  logic [pida_pkg::WORD_W-1:0]       res_word_r, res_word_nxt;
  pida_pkg::status_t                 res_stat_r, res_stat_nxt;
  logic [pida_pkg::CNT_W-1:0]        res_cnt_r;

  logic                              in_acc;
  logic                              commit;
  logic                              pos_ok;
  logic                              full;
  logic [pida_pkg::CMP_W-1:0]        slot_in;
  logic [pida_pkg::CMP_W-1:0]        slot_q;
  logic [pida_pkg::WORD_BITS-1:0]    rd_word;
  pida_pkg::cell_cmd_t               cmd;

  logic [pida_pkg::WORD_BITS-1:0]    cell_word [pida_pkg::DEPTH];
  logic                              cell_vld  [pida_pkg::DEPTH];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign commit    = (state_r == S_WB) && (!out_vld_r || out_tready);

  // slot of the incoming request feeds the first level of the read tree
  assign slot_in = pida_pkg::CMP_W'(in_tdata[8:0]) - pida_pkg::CMP_W'(1);
  assign slot_q  = pida_pkg::CMP_W'(pos_r) - pida_pkg::CMP_W'(1);

  assign pos_ok = (pos_r != '0) && (pos_r <= count_r);
  assign full   = (count_r >= cap_r);

  // Broadcast the committed operation to the row; refused requests move nothing.
  always_comb begin
    cmd.en    = commit && pos_ok && !(kind_r == pida_pkg::REQ_INS && full);
    cmd.kind  = kind_r;
    cmd.slot  = slot_q;
    cmd.count = pida_pkg::CMP_W'(count_r);
    cmd.word  = word_r;
  end

  // Result and next count for the request in the commit stage.
  always_comb begin
    res_word_nxt = '0;
    res_stat_nxt = pida_pkg::ST_OK;
    count_nxt    = count_r;
    if (!pos_ok) begin
      res_stat_nxt = pida_pkg::ST_RANGE;
    end else begin
      case (kind_r)
        pida_pkg::REQ_SET: begin
          res_word_nxt = pida_pkg::WORD_W'(word_r);
        end
        pida_pkg::REQ_GET: begin
          res_word_nxt = pida_pkg::WORD_W'(rd_word);
        end
        pida_pkg::REQ_INS: begin
          if (full) begin
            res_stat_nxt = pida_pkg::ST_FULL;
          end else begin
            res_word_nxt = pida_pkg::WORD_W'(word_r);
            count_nxt    = count_r + pida_pkg::CNT_W'(1);
          end
        end
        pida_pkg::REQ_DEL: begin
          res_word_nxt = pida_pkg::WORD_W'(rd_word);
          count_nxt    = count_r - pida_pkg::CNT_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // Saturate a written capacity to the depth.
  always_comb begin
    if (pida_pkg::CMP_W'(cfg_wr_data) > pida_pkg::CMP_W'(pida_pkg::DEPTH)) begin
      cap_nxt = pida_pkg::CNT_W'(pida_pkg::DEPTH);
    end else begin
      cap_nxt = cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
      cap_r     <= pida_pkg::CNT_W'(pida_pkg::CAP_RESET);
      count_r   <= pida_pkg::CNT_W'(pida_pkg::CAP_RESET);
    end else begin
      // load the result on a commit, drop it once taken
      if (commit) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            state_r <= S_RD;
          end
        end
        S_RD: begin
          state_r <= S_WB;
        end
        S_WB: begin
          // hold here until the result register is free
          if (commit) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      // configuration must arrive only while idle; the block itself does not enforce it
      if (cfg_wr_en) begin
        cap_r   <= cap_nxt;
        count_r <= cap_nxt;
      end else if (commit) begin
        count_r <= count_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r <= pida_pkg::req_kind_t'(in_tuser);
      pos_r  <= in_tdata[8:0];
      word_r <= pida_pkg::WORD_BITS'(in_tdata[72:9]);
    end
    if (commit) begin
      res_word_r <= res_word_nxt;
      res_stat_r <= res_stat_nxt;
      res_cnt_r  <= count_nxt;
    end
  end

  // Row of cells; each neighbors the next, with zero fed in at both ends.
  for (genvar i = 0; i < pida_pkg::DEPTH; i++) begin : g_cell
    logic [pida_pkg::WORD_BITS-1:0] lw, rw;
    logic                           lv, rv;
    if (i == 0) begin : g_first
      assign lw = '0;
      assign lv = 1'b0;
    end else begin : g_left
      assign lw = cell_word[i-1];
      assign lv = cell_vld[i-1];
    end
    if (i == pida_pkg::DEPTH - 1) begin : g_last
      assign rw = '0;
      assign rv = 1'b0;
    end else begin : g_right
      assign rw = cell_word[i+1];
      assign rv = cell_vld[i+1];
    end
    pida_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .idx        (pida_pkg::CMP_W'(i)),
      .left_word  (lw),
      .left_vld   (lv),
      .right_word (rw),
      .right_vld  (rv),
      .word       (cell_word[i]),
      .vld        (cell_vld[i])
    );
  end

  pida_rdmux u_rdmux (
    .clk     (clk),
    .words   (cell_word),
    .ld_grp  (in_acc),
    .slot    (slot_in[pida_pkg::IDX_W-1:0]),
    .ld_out  (state_r == S_RD),
    .rd_word (rd_word)
  );

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'b0000, (res_cnt_r == '0), res_cnt_r, res_stat_r, res_word_r};

endmodule

// ===== verif/tb_positional_insert_delete_array_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_positional_insert_delete_array_unit: self-checking bench for the array unit
// Drives set, get, insert and delete requests over the request stream, keeps
// its own model of the word store, count and capacity, and compares every
// result transaction field by field, in order, against the model or, for typed
// rows, their typed values. A short table of directed requests comes first, then
// random phases under varying capacity, idle and backpressure patterns.
// ----------------------------------------------------------------------------
module tb_positional_insert_delete_array_unit;

  // cycles without any transaction before the run is declared hung
  localparam int HANG_LIMIT   = 3000;
  // pipeline depth of the unit, used for the quiet time around register writes
  localparam int PIPE_CYCLES  = 3;
  localparam int HOLD_CYCLES  = 300;
  localparam int ITEMS_PHASE  = 50;
  localparam int NUM_PHASES   = 8;

  // one result transaction, split into its fields
  typedef struct packed {
    logic [63:0]       word;
    pida_pkg::status_t status;
    logic [8:0]        count;
    logic              empty;
  } result_t;

  // one row of the directed table: a request or a capacity write
  typedef struct {
    bit                  is_cfg;
    logic [8:0]          cap;
    pida_pkg::req_kind_t kind;
    logic [8:0]          pos;
    logic [63:0]         word;
    bit                  typed;
    result_t             exp;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [8:0]  cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [1:0]  in_tuser;
  logic [79:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;

  // model state of the unit
  logic [63:0] word_store [0:pida_pkg::DEPTH-1];
  int          fill_count;
  int          capacity;

  // results still owed by the unit, oldest first
  result_t     owed_results [$];
  stim_row_t   directed_rows [$];

  // what the request currently on the bus expects, when typed in by hand
  bit          row_typed;
  result_t     row_exp;

  int          error_count = 0;
  int          quiet_cycles = 0;
  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          hold_left = 0;

  positional_insert_delete_array_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tuser    (in_tuser),    // [1:0] req_type
    .in_tdata    (in_tdata),    // [8:0] position, [72:9] word_in, [79:73] zero
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)    // [63:0] word_out, [65:64] status,
                                // [74:66] element_count, [75] is_empty
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Apply one request to the model and return the result it must produce.
  function automatic result_t apply_request(pida_pkg::req_kind_t kind, logic [8:0] pos,
                                            logic [63:0] word);
    result_t r;
    int      slot;
    int      i;
    r = '0;
    r.status = pida_pkg::ST_OK;
    if (pos < 1 || pos > fill_count) begin
      // out of range: nothing moves, word reads as zero
      r.status = pida_pkg::ST_RANGE;
    end else begin
      slot = pos - 1;
      case (kind)
        pida_pkg::REQ_SET: begin
          word_store[slot] = word;
          r.word = word;
        end
        pida_pkg::REQ_GET: begin
          r.word = word_store[slot];
        end
        pida_pkg::REQ_INS: begin
          if (fill_count >= capacity) begin
            r.status = pida_pkg::ST_FULL;
          end else begin
            for (i = fill_count; i > slot; i--) word_store[i] = word_store[i-1];
            word_store[slot] = word;
            fill_count++;
            r.word = word;
          end
        end
        default: begin
          // delete: the vacated top slot keeps its old word
          r.word = word_store[slot];
          for (i = slot; i + 1 < fill_count; i++) word_store[i] = word_store[i+1];
          fill_count--;
        end
      endcase
    end
    r.count = fill_count[8:0];
    r.empty = (fill_count == 0);
    return r;
  endfunction

  function automatic result_t mk_result(logic [63:0] w, pida_pkg::status_t s, int c);
    result_t r;
    r.word   = w;
    r.status = s;
    r.count  = c[8:0];
    r.empty  = (c == 0);
    return r;
  endfunction

  task automatic add_req(pida_pkg::req_kind_t k, int p, logic [63:0] w, bit typed,
                         result_t e);
    stim_row_t row;
    row.is_cfg = 1'b0;
    row.cap    = '0;
    row.kind   = k;
    row.pos    = p[8:0];
    row.word   = w;
    row.typed  = typed;
    row.exp    = e;
    directed_rows.push_back(row);
  endtask

  task automatic add_cfg(int v);
    stim_row_t row;
    row.is_cfg = 1'b1;
    row.cap    = v[8:0];
    row.kind   = pida_pkg::REQ_SET;
    row.pos    = '0;
    row.word   = '0;
    row.typed  = 1'b0;
    row.exp    = '0;
    directed_rows.push_back(row);
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    error_count++;
  endtask

  // Wait for every owed result, then keep the input quiet past the pipeline depth.
  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (owed_results.size() != 0) @(negedge clk);
    repeat (PIPE_CYCLES + 2) @(negedge clk);
  endtask

  // Write the capacity register while the unit is idle; the count follows it.
  task automatic write_capacity(logic [8:0] v);
    wait_drained();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    capacity    = (v > pida_pkg::DEPTH) ? pida_pkg::DEPTH : v;
    fill_count  = capacity;
  endtask

  // Offer one request, wait for its transaction, then maybe idle a while.
  // Valid stays high across back-to-back transactions.
  task automatic send_req(pida_pkg::req_kind_t k, logic [8:0] pos, logic [63:0] w,
                          bit typed, result_t e);
    in_tuser  = k;
    in_tdata  = {7'b0, w, pos};
    row_typed = typed;
    row_exp   = e;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    if ($urandom_range(99, 0) < tx_idle_pct) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
  endtask

  // Bias positions into the live range, with edges and noise mixed in.
  function automatic logic [8:0] pick_position();
    int r;
    r = $urandom_range(99, 0);
    if (fill_count > 0 && r < 80) return 9'($urandom_range(fill_count, 1));
    if (r < 88) return 9'(fill_count + 1);
    if (r < 93) return 9'd0;
    return 9'($urandom_range(511, 0));
  endfunction

  function automatic pida_pkg::req_kind_t pick_kind();
    int r;
    r = $urandom_range(99, 0);
    if (r < 20) return pida_pkg::REQ_SET;
    if (r < 40) return pida_pkg::REQ_GET;
    if (r < 70) return pida_pkg::REQ_INS;
    return pida_pkg::REQ_DEL;
  endfunction

  // Receiver: random stalls per phase, plus a long hold-off on request.
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_tready = 1'b0;
      hold_left--;
    end else begin
      out_tready = ($urandom_range(99, 0) >= rx_stall_pct);
    end
  end

  // Monitor: predict on each accepted request, check each accepted result,
  // and watch for a hung pipeline.
  always @(posedge clk) begin
    result_t pred;
    result_t want;
    result_t got;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        pred = apply_request(pida_pkg::req_kind_t'(in_tuser), in_tdata[8:0],
                             in_tdata[72:9]);
        // hand-typed rows are checked against their typed values
        owed_results.push_back(row_typed ? row_exp : pred);
      end
      if (out_tvalid && out_tready) begin
        got.word   = out_tdata[63:0];
        got.status = pida_pkg::status_t'(out_tdata[65:64]);
        got.count  = out_tdata[74:66];
        got.empty  = out_tdata[75];
        if (owed_results.size() == 0) begin
          report_mismatch("unexpected result", out_tdata[63:0], '0);
        end else begin
          want = owed_results.pop_front();
          if (got.word !== want.word) report_mismatch("word_out", got.word, want.word);
          if (got.status !== want.status)
            report_mismatch("status", got.status, want.status);
          if (got.count !== want.count)
            report_mismatch("element_count", got.count, want.count);
          if (got.empty !== want.empty) report_mismatch("is_empty", got.empty, want.empty);
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("tb_positional_insert_delete_array_unit: done, errors");
        $finish;
      end
    end
  end

  initial begin
    logic [63:0] ones;
    int          ph;
    int          n;
    int          mode;
    int          caps [NUM_PHASES];
    stim_row_t   row;

    ones = '1;
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_tvalid   = 1'b0;
    in_tuser    = '0;
    in_tdata    = '0;
    row_typed   = 1'b0;
    row_exp     = '0;

    // model after reset: store cleared, full at capacity 256
    for (int i = 0; i < pida_pkg::DEPTH; i++) word_store[i] = '0;
    capacity   = pida_pkg::CAP_RESET;
    fill_count = capacity;

    // directed table; typed rows carry their expected result
    add_req(pida_pkg::REQ_GET, 1,   '0,   1, mk_result('0, pida_pkg::ST_OK, 256));
    add_req(pida_pkg::REQ_GET, 256, '0,   1, mk_result('0, pida_pkg::ST_OK, 256));
    add_req(pida_pkg::REQ_GET, 0,   '0,   1, mk_result('0, pida_pkg::ST_RANGE, 256));
    add_req(pida_pkg::REQ_SET, 257, ones, 1, mk_result('0, pida_pkg::ST_RANGE, 256));
    add_req(pida_pkg::REQ_DEL, 511, '0,   1, mk_result('0, pida_pkg::ST_RANGE, 256));
    add_req(pida_pkg::REQ_INS, 1,   ones, 1, mk_result('0, pida_pkg::ST_FULL, 256));
    add_req(pida_pkg::REQ_SET, 256, ones, 1, mk_result(ones, pida_pkg::ST_OK, 256));
    add_req(pida_pkg::REQ_GET, 256, '0,   1, mk_result(ones, pida_pkg::ST_OK, 256));
    add_req(pida_pkg::REQ_DEL, 256, '0,   1, mk_result(ones, pida_pkg::ST_OK, 255));
    add_req(pida_pkg::REQ_INS, 1, 64'h0123_4567_89ab_cdef, 1,
            mk_result(64'h0123_4567_89ab_cdef, pida_pkg::ST_OK, 256));
    add_req(pida_pkg::REQ_GET, 2,   '0,   0, '0);
    add_req(pida_pkg::REQ_DEL, 1,   '0,   1,
            mk_result(64'h0123_4567_89ab_cdef, pida_pkg::ST_OK, 255));
    // empty array: every request is out of range, insert included
    add_cfg(0);
    add_req(pida_pkg::REQ_GET, 1,   '0,   1, mk_result('0, pida_pkg::ST_RANGE, 0));
    add_req(pida_pkg::REQ_INS, 1,   ones, 1, mk_result('0, pida_pkg::ST_RANGE, 0));
    // oversized capacity saturates to the depth; stale words show through
    add_cfg(511);
    add_req(pida_pkg::REQ_GET, 256, '0,   0, '0);
    add_cfg(2);
    add_req(pida_pkg::REQ_SET, 1, 64'h5555_5555_5555_5555, 1,
            mk_result(64'h5555_5555_5555_5555, pida_pkg::ST_OK, 2));
    add_req(pida_pkg::REQ_DEL, 2,   '0,   0, '0);
    add_req(pida_pkg::REQ_INS, 1, 64'haaaa_aaaa_aaaa_aaaa, 0, '0);
    add_req(pida_pkg::REQ_INS, 1,   ones, 1, mk_result('0, pida_pkg::ST_FULL, 2));
    add_req(pida_pkg::REQ_DEL, 1,   '0,   0, '0);
    add_req(pida_pkg::REQ_DEL, 1,   '0,   0, '0);
    add_cfg(3);
    add_req(pida_pkg::REQ_GET, 3,   '0,   0, '0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // walk the directed table with no idling
    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      if (row.is_cfg) write_capacity(row.cap);
      else send_req(row.kind, row.pos, row.word, row.typed, row.exp);
    end

    // random phases: capacities cover the extremes and small arrays
    caps = '{1, 511, 6, 0, 16, 2, 256, 0};
    caps[NUM_PHASES-1] = $urandom_range(511, 0);
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      write_capacity(caps[ph][8:0]);
      mode = ph % 4;
      tx_idle_pct  = (mode == 1) ? 60 : (mode == 3) ? 27 : 0;
      rx_stall_pct = (mode == 2) ? 60 : (mode == 3) ? 27 : 0;
      for (n = 0; n < ITEMS_PHASE; n++) begin
        // hold off the receiver long enough to back up the input
        if (ph == 4 && n == 10) hold_req++;
        // pause the sender until everything owed has come back
        if (ph == 5 && n == 25) wait_drained();
        send_req(pick_kind(), pick_position(), {$urandom, $urandom}, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_positional_insert_delete_array_unit: done, clean");
    end else begin
      $display("tb_positional_insert_delete_array_unit: done, errors");
    end
    $finish;
  end

endmodule
